// ===== src/fsd_pkg.sv =====
// Package for the Floyd-Steinberg RGB dither block.
// Holds pixel payload types, register indexes, sequencer states and the quantizer
// reciprocal table. It depends on nothing else.
`timescale 1ns / 1ps

package fsd_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int ErrorBitsDef = 12;
  localparam int MaxHeight    = 4096;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  // Position flags that the front end attaches to every pixel.
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
  } item_tag_t;

  typedef enum logic [1:0] {
    REG_QUANT_BITS   = 2'd0,
    REG_LINE_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MULV,
    ST_DIV1,
    ST_NUM,
    ST_RECIP,
    ST_FIX,
    ST_WRITE,
    ST_TAIL
  } back_state_e;

  // floor(65536 / (2^bits - 1)) + 1, an upper reciprocal that is off by at most one.
  function automatic logic [14:0] recip_f(input logic [3:0] bits);
    logic [14:0] r;
    unique case (bits)
      4'd2:    r = 15'd21846;
      4'd3:    r = 15'd9363;
      4'd4:    r = 15'd4370;
      4'd5:    r = 15'd2115;
      4'd6:    r = 15'd1041;
      4'd7:    r = 15'd517;
      default: r = 15'd258;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] chan_f(input pix_in_t p, input int ch);
    logic [7:0] c;
    case (ch)
      0:       c = p.red_in;
      1:       c = p.green_in;
      default: c = p.blue_in;
    endcase
    return c;
  endfunction

endpackage

// ===== src/fsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
`timescale 1ns / 1ps

module fsd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fsd_fifo.sv =====
// Short request queue between the front end and the back end.
// Depends on nothing else.
`timescale 1ns / 1ps

module fsd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0]   count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (32'(count_q) < DEPTH);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = buf_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : PW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : PW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= CNW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CNW'(count_q - 1'b1);
      end
    end
  end

endmodule

// ===== src/fsd_front.sv =====
// Front end: accepts pixels and tags each with its column and row position.
// Depends on fsd_pkg.
`timescale 1ns / 1ps

module fsd_front import fsd_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [8:0]      line_width_i,
  input  logic [12:0]     frame_height_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            queue_ready_i,
  output logic            push_o,
  output logic [CW-1:0]   col_o,
  output item_tag_t       tag_o
);

  logic [CW-1:0] col_q;
  logic [11:0]   row_q;
  logic          last_row;
  logic          accept;

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i;
  assign accept     = in_valid_i && queue_ready_i;

  assign col_o           = col_q;
  assign tag_o.first_col = (col_q == '0);
  assign tag_o.last_col  = (32'(col_q) == 32'(line_width_i) - 1);
  assign tag_o.first_row = (row_q == '0);
  assign last_row        = (32'(row_q) == 32'(frame_height_i) - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (tag_o.last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : 12'(row_q + 1'b1);
      end else begin
        col_q <= CW'(col_q + 1'b1);
      end
    end
  end

endmodule

// ===== src/fsd_back.sv =====
// Back end: per-pixel sequencer that adds diffused error, quantizes the three
// color channels and accumulates next-row error in a row RAM. Depends on fsd_pkg, fsd_ram.
`timescale 1ns / 1ps

module fsd_back import fsd_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int ERROR_BITS = ErrorBitsDef,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [3:0]    quant_bits_i,
  input  logic          item_valid_i,
  output logic          item_pop_o,
  input  pix_in_t       item_pix_i,
  input  logic [CW-1:0] item_col_i,
  input  item_tag_t     item_tag_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pix_out_t      out_data_o
);

  localparam int EW = ERROR_BITS;
  localparam int SW = ERROR_BITS + 4;
  localparam int MW = 3 * ERROR_BITS;

  function automatic logic signed [EW-1:0] sat_f(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((64'sd1 <<< (EW - 1)) - 1);
    lo = -hi - SW'(1);
    if (s > hi) return EW'(hi);
    if (s < lo) return EW'(lo);
    return EW'(s);
  endfunction

  back_state_e state_q, state_d;

  pix_in_t       pix_q;
  logic [CW-1:0] col_q;
  item_tag_t     tag_q;
  logic          out_valid_q;
  pix_out_t      out_data_q;

  logic [7:0]        v_q  [3];
  logic [15:0]       x1_q [3];
  logic [7:0]        a_q  [3];
  logic [15:0]       n_q  [3];
  logic [14:0]       a2_q [3];
  logic [7:0]        o_q  [3];
  logic signed [8:0] d_q  [3];
  logic signed [8:0] d1_q [3];
  logic signed [8:0] d2_q [3];

  logic [7:0]        lm1;
  logic [7:0]        half;
  logic [14:0]       recip;
  logic              out_free;
  logic              load_out;

  logic [7:0]        v_c   [3];
  logic [15:0]       x1_c  [3];
  logic [7:0]        a_c   [3];
  logic [15:0]       n_c   [3];
  logic [14:0]       a2_c  [3];
  logic [7:0]        o_c   [3];
  logic signed [8:0] d_c   [3];
  logic signed [8:0] d1e   [3];
  logic signed [8:0] d2e   [3];
  logic [MW-1:0]     wdata_row;
  logic [MW-1:0]     wdata_tail;

  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [MW-1:0]     ram_wdata;
  logic [MW-1:0]     ram_rdata;

  assign lm1      = 8'((9'd1 << quant_bits_i) - 9'd1);
  assign half     = lm1 >> 1;
  assign recip    = recip_f(quant_bits_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = (state_q == ST_WRITE) && out_free;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  always_comb begin
    logic signed [EW-1:0] nprev;
    logic signed [EW-1:0] e;
    logic signed [EW:0]   et;
    logic signed [EW:0]   ediv;
    logic signed [SW-1:0] vs;
    logic [23:0]          p257;
    logic [16:0]          r;
    logic [7:0]           q;
    logic [30:0]          p;
    logic [22:0]          prod;
    for (int c = 0; c < 3; c++) begin
      d1e[c] = tag_q.first_col ? 9'sd0 : d1_q[c];
      d2e[c] = tag_q.first_col ? 9'sd0 : d2_q[c];
      nprev  = tag_q.first_row ? '0 : signed'(ram_rdata[c*EW +: EW]);
      e      = sat_f(SW'(nprev) + SW'(d1e[c]) * SW'(7));
      // Divide by 16 with truncation toward zero.
      et     = (EW+1)'(e) + (e[EW-1] ? (EW+1)'(15) : (EW+1)'(0));
      ediv   = et >>> 4;
      vs     = SW'(signed'({1'b0, chan_f(pix_q, c)})) + SW'(ediv);
      if (vs < 0) begin
        v_c[c] = 8'd0;
      end else if (vs > SW'(255)) begin
        v_c[c] = 8'd255;
      end else begin
        v_c[c] = 8'(vs);
      end

      x1_c[c] = 16'(v_q[c]) * 16'(lm1) + 16'd127;

      // x1 / 255: low estimate, fixed up by one compare.
      p257   = 24'(x1_q[c]) * 24'd257;
      a_c[c] = p257[23:16];

      r       = 17'(x1_q[c]) - 17'(a_q[c]) * 17'd255;
      q       = (r >= 17'd255) ? 8'(a_q[c] + 1'b1) : a_q[c];
      n_c[c]  = 16'(q) * 16'd255 + 16'(half);

      // n / lm1: high estimate, fixed up by one compare.
      p       = 31'(n_q[c]) * 31'(recip);
      a2_c[c] = p[30:16];

      prod    = 23'(a2_q[c]) * 23'(lm1);
      o_c[c]  = (prod > 23'(n_q[c])) ? 8'(a2_q[c] - 1'b1) : 8'(a2_q[c]);
      d_c[c]  = (pix_q.alpha_in == 8'd0) ? 9'sd0 :
                signed'({1'b0, v_q[c]}) - signed'({1'b0, o_c[c]});

      wdata_row[c*EW +: EW]  = sat_f(SW'(d_q[c]) * SW'(3) + SW'(d1e[c]) * SW'(5)
                                     + SW'(d2e[c]));
      wdata_tail[c*EW +: EW] = sat_f(SW'(d1_q[c]) * SW'(5) + SW'(d2_q[c]));
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_q;
    ram_wdata = wdata_row;
    if (load_out && !tag_q.first_col) begin
      ram_we    = 1'b1;
      ram_waddr = CW'(col_q - 1'b1);
    end else if (state_q == ST_TAIL) begin
      ram_we    = 1'b1;
      ram_wdata = wdata_tail;
    end
  end

  fsd_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_WIDTH)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (item_pop_o),
    .raddr_i(item_col_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (item_valid_i) state_d = ST_ERR;
      ST_ERR:   state_d = ST_MULV;
      ST_MULV:  state_d = ST_DIV1;
      ST_DIV1:  state_d = ST_NUM;
      ST_NUM:   state_d = ST_RECIP;
      ST_RECIP: state_d = ST_FIX;
      ST_FIX:   state_d = ST_WRITE;
      ST_WRITE: if (out_free) state_d = tag_q.last_col ? ST_TAIL : ST_IDLE;
      ST_TAIL:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      pix_q <= item_pix_i;
      col_q <= item_col_i;
      tag_q <= item_tag_i;
    end
    for (int c = 0; c < 3; c++) begin
      if (state_q == ST_ERR)   v_q[c]  <= v_c[c];
      if (state_q == ST_MULV)  x1_q[c] <= x1_c[c];
      if (state_q == ST_DIV1)  a_q[c]  <= a_c[c];
      if (state_q == ST_NUM)   n_q[c]  <= n_c[c];
      if (state_q == ST_RECIP) a2_q[c] <= a2_c[c];
      if (state_q == ST_FIX) begin
        o_q[c] <= o_c[c];
        d_q[c] <= d_c[c];
      end
      if (load_out) begin
        d1_q[c] <= d_q[c];
        d2_q[c] <= d1e[c];
      end
    end
    if (load_out) begin
      out_data_q.red_out   <= o_q[0];
      out_data_q.green_out <= o_q[1];
      out_data_q.blue_out  <= o_q[2];
      out_data_q.alpha_out <= pix_q.alpha_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/floyd_steinberg_dither_rgb.sv =====
// Top level of the Floyd-Steinberg RGB dither block: APB registers, front end,
// request queue and back end. Depends on fsd_pkg, fsd_front, fsd_fifo, fsd_back.
`timescale 1ns / 1ps

// This block dithers a raster-order stream of RGBA pixels down to 2^quant_bits
// levels per color channel and returns one pixel for every pixel it takes in.
// The error left over by each channel is spread over the neighbors with the
// classic 7/16, 3/16, 5/16 and 1/16 weights; error that would fall past the
// row edges is dropped, and a pixel with zero alpha spreads no error. Alpha
// passes through untouched. Error for the row below is kept in one row RAM
// of MAX_WIDTH entries, while the error toward the right neighbor lives in
// registers. The front end tags every request with its column and row and
// parks it in a two-deep queue, so the input side keeps taking requests, until
// the queue is full, while a finished pixel waits at the output register. The
// back end works on one request at a time and pops the next only once back in
// idle. The last pixel of a row adds a tail step for a second row RAM write,
// and the write step holds while the output is stalled. The quantizer steps
// are error add, scale, divide by 255, reciprocal divide by 2^quant_bits - 1
// and correction. Any write to one of the three registers restarts the frame;
// the error of the first row of each frame reads as zero, so no clearing pass
// is needed after reset. Registers sit at byte addresses 0, 4 and 8.
module floyd_steinberg_dither_rgb import fsd_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int ERROR_BITS = ErrorBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pix_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pix_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = $bits(pix_in_t) + CW + $bits(item_tag_t);

  logic [3:0]  quant_bits_q;
  logic [8:0]  line_width_q;
  logic [12:0] frame_height_q;
  logic        cfg_write;
  logic        restart;
  reg_idx_e    reg_idx;

  logic          push, queue_ready, item_valid, item_pop;
  logic [CW-1:0] front_col, item_col;
  item_tag_t     front_tag, item_tag;
  pix_in_t       item_pix;
  logic [QW-1:0] item_word;

  // A write completes in the access phase; pready never holds it off.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign restart   = cfg_write && (reg_idx != REG_NONE);

  // Writes saturate into each register's legal range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_bits_q   <= 4'd3;
      line_width_q   <= 9'd100;
      frame_height_q <= 13'd100;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_QUANT_BITS: begin
          if (pwdata[3:0] < 4'd2) begin
            quant_bits_q <= 4'd2;
          end else if (pwdata[3:0] > 4'd8) begin
            quant_bits_q <= 4'd8;
          end else begin
            quant_bits_q <= pwdata[3:0];
          end
        end
        REG_LINE_WIDTH: begin
          if (pwdata[8:0] == 9'd0) begin
            line_width_q <= 9'd1;
          end else if (32'(pwdata[8:0]) > MAX_WIDTH) begin
            line_width_q <= 9'(MAX_WIDTH);
          end else begin
            line_width_q <= pwdata[8:0];
          end
        end
        REG_FRAME_HEIGHT: begin
          if (pwdata[12:0] == 13'd0) begin
            frame_height_q <= 13'd1;
          end else if (32'(pwdata[12:0]) > MaxHeight) begin
            frame_height_q <= 13'(MaxHeight);
          end else begin
            frame_height_q <= pwdata[12:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUANT_BITS:   prdata = 32'(quant_bits_q);
      REG_LINE_WIDTH:   prdata = 32'(line_width_q);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // The front end classifies each request by position in the frame.
  fsd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .line_width_i  (line_width_q),
    .frame_height_i(frame_height_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .col_o         (front_col),
    .tag_o         (front_tag)
  );

  // The queue decouples request intake from the quantizer sequencer.
  fsd_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({in_data_i, front_col, front_tag}),
    .push_ready_o(queue_ready),
    .pop_i       (item_pop),
    .pop_valid_o (item_valid),
    .pop_data_o  (item_word)
  );

  assign {item_pix, item_col, item_tag} = item_word;

  // The back end runs the dither arithmetic and owns the output register.
  fsd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .ERROR_BITS(ERROR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quant_bits_i(quant_bits_q),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .item_pix_i  (item_pix),
    .item_col_i  (item_col),
    .item_tag_i  (item_tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
